FILE: hw/rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, codes and helpers for the go-back-n sender window unit.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_W   = 8;
  localparam int MOD_W   = 9;
  localparam int WINF_W  = 6;
  localparam int TICK_W  = 16;
  localparam int SCNT_W  = 16;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 16;

  // longest retransmit burst
  localparam int BURST_MAX = 32;
  localparam int BURST_W   = 6;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_WINDOW  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MODULUS = 2'd1;
  localparam logic [CIDX_W-1:0] REG_TIMEOUT = 2'd2;
  localparam logic [CIDX_W-1:0] REG_SEGMENTS = 2'd3;

  // register reset values
  localparam logic [WINF_W-1:0] RST_WINDOW   = 6'd20;
  localparam logic [MOD_W-1:0]  RST_MODULUS  = 9'd201;
  localparam logic [TICK_W-1:0] RST_TIMEOUT  = 16'd1000;
  localparam logic [SCNT_W-1:0] RST_SEGMENTS = 16'd1;

  // modulus clamp bounds
  localparam logic [MOD_W-1:0] MOD_MIN = 9'd2;
  localparam logic [MOD_W-1:0] MOD_MAX = 9'd256;

  // input item modes
  localparam logic [1:0] MODE_SEND = 2'd0;
  localparam logic [1:0] MODE_ACK  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  typedef enum logic [2:0] {
    KIND_NEW     = 3'd0,
    KIND_REFUSED = 3'd1,
    KIND_RESEND  = 3'd2,
    KIND_ACK     = 3'd3,
    KIND_DONE    = 3'd4,
    KIND_IDLE    = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_REFUSE,
    OP_NEW,
    OP_IDLE,
    OP_DONE,
    OP_ACK,
    OP_TICK,
    OP_TICK_STOP,
    OP_BURST,
    OP_STEP
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY,
    S_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    op_t  dec;
    logic burst_more;
  } sts_t;

  // wrapping increment in a sequence space of size m
  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] n;
    n = {1'b0, s} + 9'd1;
    return (n >= m) ? '0 : n[SEQ_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/gbn_if.sv
// ----------------------------------------------------------------------------
// gbn channel interfaces
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gbn_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic [gbn_pkg::SEQ_W-1:0]  ack_seq;
  logic                       ack_more;

  modport source(output valid, mode, ack_seq, ack_more, input ready);
  modport sink(input valid, mode, ack_seq, ack_more, output ready);
endinterface

interface gbn_rsp_if #(
  parameter int INDEX_WIDTH = 16
);
  logic                       valid;
  logic                       ready;
  logic [2:0]                 kind;
  logic [gbn_pkg::SEQ_W-1:0]  seq_number;
  logic [INDEX_WIDTH-1:0]     segment_index;
  logic                       more_follow;
  logic                       last;

  modport source(output valid, kind, seq_number, segment_index, more_follow, last,
                 input ready);
  modport sink(input valid, kind, seq_number, segment_index, more_follow, last,
               output ready);
endinterface

interface gbn_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [gbn_pkg::CIDX_W-1:0]  index;
  logic [gbn_pkg::CDAT_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: hw/rtl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer: accept, evaluate, update, present results (burst stepping).
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  gbn_pkg::sts_t sts,
  output gbn_pkg::cmd_t cmd
);

  gbn_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.eval   = 1'b0;
    cmd.op     = gbn_pkg::OP_NONE;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      gbn_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = gbn_pkg::S_EVAL;
        end
      end
      gbn_pkg::S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = gbn_pkg::S_APPLY;
      end
      gbn_pkg::S_APPLY: begin
        cmd.op     = sts.dec;
        state_next = gbn_pkg::S_SEND;
      end
      gbn_pkg::S_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.burst_more) begin
            cmd.op = gbn_pkg::OP_STEP;
          end else begin
            state_next = gbn_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = gbn_pkg::S_IDLE;
      end
    endcase
  end

  a_load_to_eval: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == gbn_pkg::S_EVAL)
    else $error("accepted item not evaluated");

  a_burst_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && sts.burst_more |=> out_valid)
    else $error("burst ended early");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

endmodule

FILE: hw/rtl/gbn_dpath.sv
// ----------------------------------------------------------------------------
// gbn_dpath
// Window state, timer, register file, decision logic and result register.
// ----------------------------------------------------------------------------
module gbn_dpath #(
  parameter int MAX_WINDOW  = 32,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [gbn_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [gbn_pkg::CDAT_W-1:0]  cfg_data,
  input  logic [1:0]                  in_mode,
  input  logic [gbn_pkg::SEQ_W-1:0]   in_ack_seq,
  input  logic                        in_ack_more,
  input  gbn_pkg::cmd_t               cmd,
  output gbn_pkg::sts_t               sts,
  output gbn_pkg::kind_t              rsp_kind,
  output logic [gbn_pkg::SEQ_W-1:0]   rsp_seq,
  output logic [INDEX_WIDTH-1:0]      rsp_index,
  output logic                        rsp_more,
  output logic                        rsp_last
);

  localparam int IW = INDEX_WIDTH;
  localparam int SW = gbn_pkg::SEQ_W;
  localparam int MW = gbn_pkg::MOD_W;
  localparam int TW = gbn_pkg::TICK_W;
  localparam int BW = gbn_pkg::BURST_W;
  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int CW = (IW > gbn_pkg::SCNT_W) ? IW : gbn_pkg::SCNT_W;
  localparam int DW = (IW > MW) ? IW : MW;

  // register file
  logic [gbn_pkg::WINF_W-1:0] window_size;
  logic [MW-1:0]              seq_modulus;
  logic [TW-1:0]              timeout_ticks;
  logic [gbn_pkg::SCNT_W-1:0] segment_count;

  // effective (clamped) settings
  logic [MW-1:0] eff_mod;
  logic [WW-1:0] eff_win;
  logic [IW-1:0] eff_total;
  logic [TW-1:0] eff_limit;
  logic [MW-1:0] mod_c;
  logic [MW-1:0] win_c;
  logic [CW-1:0] cnt_c;
  logic [CW-1:0] idx_max;

  // window state
  logic [SW-1:0] base_seq;
  logic [SW-1:0] next_seq;
  logic [IW-1:0] base_index;
  logic [IW-1:0] next_index;
  logic          timer_on;
  logic [TW-1:0] timer_count;
  logic          finished;

  // captured item and evaluation results
  logic [1:0]    mode;
  logic [SW-1:0] ack_seq;
  logic          ack_more;
  gbn_pkg::op_t  dec;
  logic [MW-1:0] ack_dist;
  logic [IW-1:0] outst;
  logic          ack_empty;

  // burst walker
  logic [SW-1:0] rs;
  logic [IW-1:0] ri;
  logic [BW-1:0] rem;

  // combinational evaluation
  logic [IW-1:0] outst_c;
  logic [MW-1:0] dist_c;
  logic [TW-1:0] cnt_inc;
  logic          timeout;
  gbn_pkg::op_t  dec_c;
  logic [BW-1:0] burst_n;
  logic [IW-1:0] base_index_new;

  function automatic logic more_after(input logic [IW-1:0] idx,
                                      input logic [IW-1:0] total);
    return ({1'b0, idx} + (IW+1)'(1)) < {1'b0, total};
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= gbn_pkg::RST_WINDOW;
      seq_modulus   <= gbn_pkg::RST_MODULUS;
      timeout_ticks <= gbn_pkg::RST_TIMEOUT;
      segment_count <= gbn_pkg::RST_SEGMENTS;
    end else if (cfg_we) begin
      case (cfg_index)
        gbn_pkg::REG_WINDOW:   window_size   <= cfg_data[gbn_pkg::WINF_W-1:0];
        gbn_pkg::REG_MODULUS:  seq_modulus   <= cfg_data[MW-1:0];
        gbn_pkg::REG_TIMEOUT:  timeout_ticks <= cfg_data[TW-1:0];
        gbn_pkg::REG_SEGMENTS: segment_count <= cfg_data[gbn_pkg::SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamping, registered once per cycle
  always_comb begin
    idx_max = CW'({IW{1'b1}});
    if (seq_modulus < gbn_pkg::MOD_MIN) begin
      mod_c = gbn_pkg::MOD_MIN;
    end else if (seq_modulus > gbn_pkg::MOD_MAX) begin
      mod_c = gbn_pkg::MOD_MAX;
    end else begin
      mod_c = seq_modulus;
    end
    win_c = (window_size == '0) ? MW'(1) : MW'(window_size);
    if (win_c > MW'(MAX_WINDOW)) begin
      win_c = MW'(MAX_WINDOW);
    end
    if (win_c > mod_c - MW'(1)) begin
      win_c = mod_c - MW'(1);
    end
    cnt_c = (CW'(segment_count) > idx_max) ? idx_max : CW'(segment_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_mod   <= gbn_pkg::RST_MODULUS;
      eff_win   <= WW'(1);
      eff_total <= IW'(1);
      eff_limit <= gbn_pkg::RST_TIMEOUT;
    end else begin
      eff_mod   <= mod_c;
      eff_win   <= win_c[WW-1:0];
      eff_total <= cnt_c[IW-1:0];
      eff_limit <= (timeout_ticks == '0) ? TW'(1) : timeout_ticks;
    end
  end

  // decision for the captured item
  always_comb begin
    outst_c = next_index - base_index;
    if (ack_seq >= base_seq) begin
      dist_c = MW'(ack_seq) - MW'(base_seq);
    end else begin
      dist_c = MW'(ack_seq) + eff_mod - MW'(base_seq);
    end
    cnt_inc = (timer_count == '1) ? timer_count : timer_count + TW'(1);
    timeout = cnt_inc >= eff_limit;
    dec_c   = gbn_pkg::OP_IDLE;
    case (mode)
      gbn_pkg::MODE_SEND: begin
        if (finished || outst_c >= IW'(eff_win) || next_index >= eff_total) begin
          dec_c = gbn_pkg::OP_REFUSE;
        end else begin
          dec_c = gbn_pkg::OP_NEW;
        end
      end
      gbn_pkg::MODE_ACK: begin
        if (finished) begin
          dec_c = gbn_pkg::OP_IDLE;
        end else if (!ack_more) begin
          dec_c = gbn_pkg::OP_DONE;
        end else if (MW'(ack_seq) >= eff_mod || DW'(dist_c) >= DW'(outst_c)) begin
          dec_c = gbn_pkg::OP_IDLE;
        end else begin
          dec_c = gbn_pkg::OP_ACK;
        end
      end
      gbn_pkg::MODE_TICK: begin
        if (!finished && timer_on) begin
          if (!timeout) begin
            dec_c = gbn_pkg::OP_TICK;
          end else if (outst_c == '0) begin
            dec_c = gbn_pkg::OP_TICK_STOP;
          end else begin
            dec_c = gbn_pkg::OP_BURST;
          end
        end
      end
      default: dec_c = gbn_pkg::OP_IDLE;
    endcase
    burst_n = (outst > IW'(gbn_pkg::BURST_MAX)) ? BW'(gbn_pkg::BURST_MAX)
                                                : outst[BW-1:0];
    base_index_new = base_index + IW'(ack_dist) + IW'(1);
  end

  // item capture and evaluation registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode     <= in_mode;
      ack_seq  <= in_ack_seq;
      ack_more <= in_ack_more;
    end
    if (cmd.eval) begin
      ack_dist  <= dist_c;
      outst     <= outst_c;
      ack_empty <= (DW'(dist_c) + DW'(1)) == DW'(outst_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec <= gbn_pkg::OP_IDLE;
    end else if (cmd.eval) begin
      dec <= dec_c;
    end
  end

  // window state and timer
  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq    <= '0;
      next_seq    <= '0;
      base_index  <= '0;
      next_index  <= '0;
      timer_on    <= 1'b0;
      timer_count <= '0;
      finished    <= 1'b0;
      rem         <= '0;
    end else begin
      case (cmd.op)
        gbn_pkg::OP_NEW: begin
          if (outst == '0) begin
            timer_on    <= 1'b1;
            timer_count <= '0;
          end
          next_index <= next_index + IW'(1);
          next_seq   <= gbn_pkg::seq_inc(next_seq, eff_mod);
        end
        gbn_pkg::OP_DONE: begin
          finished <= 1'b1;
          timer_on <= 1'b0;
        end
        gbn_pkg::OP_ACK: begin
          base_index <= base_index_new;
          base_seq   <= gbn_pkg::seq_inc(ack_seq, eff_mod);
          timer_on   <= !ack_empty;
          if (!ack_empty) begin
            timer_count <= '0;
          end
        end
        gbn_pkg::OP_TICK: begin
          timer_count <= cnt_inc;
        end
        gbn_pkg::OP_TICK_STOP: begin
          timer_count <= cnt_inc;
          timer_on    <= 1'b0;
        end
        gbn_pkg::OP_BURST: begin
          timer_count <= '0;
          rem         <= burst_n - BW'(1);
        end
        gbn_pkg::OP_STEP: begin
          rem <= rem - BW'(1);
        end
        default: ;
      endcase
    end
  end

  // result register and burst walker
  always_ff @(posedge clk) begin
    case (cmd.op)
      gbn_pkg::OP_NEW: begin
        rsp_kind  <= gbn_pkg::KIND_NEW;
        rsp_seq   <= next_seq;
        rsp_index <= next_index;
        rsp_more  <= more_after(next_index, eff_total);
        rsp_last  <= 1'b1;
      end
      gbn_pkg::OP_REFUSE: begin
        rsp_kind  <= gbn_pkg::KIND_REFUSED;
        rsp_seq   <= '0;
        rsp_index <= '0;
        rsp_more  <= 1'b0;
        rsp_last  <= 1'b1;
      end
      gbn_pkg::OP_DONE: begin
        rsp_kind  <= gbn_pkg::KIND_DONE;
        rsp_seq   <= '0;
        rsp_index <= '0;
        rsp_more  <= 1'b0;
        rsp_last  <= 1'b1;
      end
      gbn_pkg::OP_ACK: begin
        rsp_kind  <= gbn_pkg::KIND_ACK;
        rsp_seq   <= ack_seq;
        rsp_index <= base_index_new;
        rsp_more  <= 1'b0;
        rsp_last  <= 1'b1;
      end
      gbn_pkg::OP_IDLE, gbn_pkg::OP_TICK, gbn_pkg::OP_TICK_STOP: begin
        rsp_kind  <= gbn_pkg::KIND_IDLE;
        rsp_seq   <= '0;
        rsp_index <= '0;
        rsp_more  <= 1'b0;
        rsp_last  <= 1'b1;
      end
      gbn_pkg::OP_BURST: begin
        rsp_kind  <= gbn_pkg::KIND_RESEND;
        rsp_seq   <= base_seq;
        rsp_index <= base_index;
        rsp_more  <= more_after(base_index, eff_total);
        rsp_last  <= burst_n == BW'(1);
        rs        <= gbn_pkg::seq_inc(base_seq, eff_mod);
        ri        <= base_index + IW'(1);
      end
      gbn_pkg::OP_STEP: begin
        rsp_kind  <= gbn_pkg::KIND_RESEND;
        rsp_seq   <= rs;
        rsp_index <= ri;
        rsp_more  <= more_after(ri, eff_total);
        rsp_last  <= rem == BW'(1);
        rs        <= gbn_pkg::seq_inc(rs, eff_mod);
        ri        <= ri + IW'(1);
      end
      default: ;
    endcase
  end

  assign sts.dec        = dec;
  assign sts.burst_more = rem != '0;

  a_done_stops_timer: assert property (@(posedge clk) disable iff (rst)
    finished |-> !timer_on)
    else $error("timer running after completion");

  a_burst_not_last: assert property (@(posedge clk) disable iff (rst)
    cmd.op == gbn_pkg::OP_BURST || cmd.op == gbn_pkg::OP_STEP
      |=> (rem != '0) == !rsp_last)
    else $error("burst last flag out of step with count");

  a_ack_moves_base: assert property (@(posedge clk) disable iff (rst)
    cmd.op == gbn_pkg::OP_ACK |=> base_index == rsp_index)
    else $error("ack result disagrees with new base");

endmodule

FILE: hw/rtl/go_back_n_sender_window_unit.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit
// Go-back-n sender window control: sends, cumulative acks, retransmit timer.
// ----------------------------------------------------------------------------
// Takes one request item at a time on req: a send request, a cumulative
// acknowledgement or a timer tick. Each item yields one result on rsp, except
// a tick that hits the timeout with segments outstanding, which yields one
// retransmit result per outstanding segment (at most 32, oldest first), the
// final one flagged with last. The first result of an item is offered once
// the item has been captured and evaluated and its state update has been
// written into the result register; further retransmits follow at one per
// cycle while rsp is ready; req is ready again the cycle after the last
// result transfers. The four-state sequencer in the controller sets this
// order. Register writes on cfg are always taken; they must be made only
// while no item is in progress, and reach the window logic through the
// register file and then the clamped settings registers. Register indexes:
// 0 window size, 1 sequence modulus, 2 timeout in ticks, 3 segment count.
// Out-of-range values are clamped: modulus to 2..256, window to
// 1..MAX_WINDOW and below the modulus, timeout 0 behaves as 1, segment
// count to the index range.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit #(
  parameter int MAX_WINDOW  = 32,
  parameter int INDEX_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  gbn_req_if.sink    req,
  gbn_rsp_if.source  rsp,
  gbn_cfg_if.sink    cfg
);

  gbn_pkg::cmd_t  cmd;
  gbn_pkg::sts_t  sts;
  gbn_pkg::kind_t kind;

  // register port never stalls
  assign cfg.ready = 1'b1;

  // sequencer: owns both handshakes
  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // window state, timer, settings and result register
  gbn_dpath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .in_mode     (req.mode),
    .in_ack_seq  (req.ack_seq),
    .in_ack_more (req.ack_more),
    .cmd         (cmd),
    .sts         (sts),
    .rsp_kind    (kind),
    .rsp_seq     (rsp.seq_number),
    .rsp_index   (rsp.segment_index),
    .rsp_more    (rsp.more_follow),
    .rsp_last    (rsp.last)
  );

  // result kind as a plain code on the channel
  assign rsp.kind = kind;

endmodule
